@@ design/kwm_pkg.sv @@
// Shared types, codes and defaults for the k-way merge engine.
package kwm_pkg;

  localparam int unsigned VAL_W          = 32;
  localparam int unsigned SEL_W          = 3;
  localparam int unsigned LISTS_DEF      = 8;
  localparam int unsigned LIST_DEPTH_DEF = 1024;
  localparam int unsigned CMDQ_DEPTH     = 2;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_CLEAR = 2'd2
  } kwm_action_e;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_POP,
    OP_CLEAR
  } kwm_op_e;

  typedef struct packed {
    kwm_action_e              action;
    logic [SEL_W-1:0]         list_select;
    logic signed [VAL_W-1:0]  load_value;
  } kwm_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]  merged_value;
    logic [SEL_W-1:0]         source_list;
    logic                     lists_exhausted;
    logic                     load_overflow;
  } kwm_out_t;

  typedef struct packed {
    kwm_op_e                  op;
    logic [SEL_W-1:0]         sel;
    logic signed [VAL_W-1:0]  value;
  } kwm_cmd_t;

endpackage

@@ design/kwm_front.sv @@
// Front end: accepts input items, decodes them into commands, drops no-op items and loads to a list beyond LISTS.
module kwm_front #(
  parameter int unsigned LISTS = kwm_pkg::LISTS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  kwm_pkg::kwm_in_t in_i,
  output logic             cmd_valid_o,
  input  logic             cmd_ready_i,
  output kwm_pkg::kwm_cmd_t cmd_o
);
  import kwm_pkg::*;

  logic     cmd_valid_q;
  kwm_cmd_t cmd_q, cmd_d;
  logic     keep_d;
  logic     accept;

  assign in_ready_o  = !cmd_valid_q || cmd_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign cmd_valid_o = cmd_valid_q;
  assign cmd_o       = cmd_q;

  always_comb begin
    keep_d      = 1'b0;
    cmd_d.op    = OP_POP;
    cmd_d.sel   = in_i.list_select;
    cmd_d.value = in_i.load_value;
    unique case (in_i.action)
      ACT_LOAD: begin
        cmd_d.op = OP_LOAD;
        keep_d   = (32'(in_i.list_select) < LISTS);
      end
      ACT_POP: begin
        cmd_d.op = OP_POP;
        keep_d   = 1'b1;
      end
      ACT_CLEAR: begin
        cmd_d.op = OP_CLEAR;
        keep_d   = 1'b1;
      end
      default: keep_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else if (accept) begin
      cmd_valid_q <= keep_d;
    end else if (cmd_ready_i) begin
      cmd_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

@@ design/kwm_cmd_fifo.sv @@
// Short command queue between the front end and the merge back end.
module kwm_cmd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  kwm_pkg::kwm_cmd_t push_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output kwm_pkg::kwm_cmd_t pop_o
);
  import kwm_pkg::*;

  localparam int unsigned PW = $clog2(CMDQ_DEPTH);
  localparam int unsigned NW = $clog2(CMDQ_DEPTH + 1);

  kwm_cmd_t        slot_q [CMDQ_DEPTH];
  logic [PW-1:0]   wptr_q, rptr_q;
  logic [NW-1:0]   count_q;
  logic            do_push, do_pop;

  assign push_ready_o = (count_q != NW'(CMDQ_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_o        = slot_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PW'(CMDQ_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PW'(CMDQ_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= push_i;
    end
  end

endmodule

@@ design/kwm_back.sv @@
// Back end: list store, per-list heads, registered min tree and pop sequencer.
module kwm_back #(
  parameter int unsigned LISTS      = kwm_pkg::LISTS_DEF,
  parameter int unsigned LIST_DEPTH = kwm_pkg::LIST_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  kwm_pkg::kwm_cmd_t cmd_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output kwm_pkg::kwm_out_t out_o
);
  import kwm_pkg::*;

  localparam int unsigned LW = $clog2(LISTS);
  localparam int unsigned P  = 1 << LW;
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned N  = LISTS * LIST_DEPTH;
  localparam int unsigned AW = $clog2(N);
  localparam int unsigned SW = $clog2(LW + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_POP, ST_FILL} state_e;

  typedef struct packed {
    logic                    vld;
    logic [LW-1:0]           idx;
    logic signed [VAL_W-1:0] val;
  } node_t;

  function automatic node_t pick(node_t a, node_t b);
    pick = (b.vld && (!a.vld || ($signed(b.val) < $signed(a.val)))) ? b : a;
  endfunction

  state_e                  state_q;
  logic                    out_valid_q;
  kwm_out_t                out_q;
  logic [LW-1:0]           fill_list_q;

  logic [VAL_W-1:0]        store_q [N];
  logic [VAL_W-1:0]        rdata_q;
  logic signed [VAL_W-1:0] head_val_q [LISTS];
  logic [LISTS-1:0]        head_vld_q;
  logic [CW-1:0]           fill_q [LISTS];
  logic [CW-1:0]           rd_q [LISTS];
  logic                    ovf_q;
  logic [SW-1:0]           settle_q, settle_d;

  node_t                   leaf [P];
  node_t                   node_q [1:P-1];
  node_t                   node_d [1:P-1];
  node_t                   root;
  logic [LW-1:0]           win;
  logic [LW-1:0]           sel_idx;

  logic [LISTS-1:0]        more, empty, ld_hit, pop_hit;
  logic                    take, do_load, do_clear, do_pop, do_fill, head_chg;
  logic                    wr_en, rd_en;
  logic [AW-1:0]           waddr, raddr;

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign take        = cmd_valid_i && cmd_ready_o;
  assign do_load     = take && (cmd_i.op == OP_LOAD);
  assign do_clear    = take && (cmd_i.op == OP_CLEAR);
  assign do_pop      = (state_q == ST_POP) && (settle_q == '0) && (!out_valid_q || out_ready_i);
  assign do_fill     = (state_q == ST_FILL);
  assign root        = node_q[1];
  assign win         = root.idx;
  assign sel_idx     = LW'(cmd_i.sel);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // per-list status
  always_comb begin
    for (int i = 0; i < LISTS; i++) begin
      empty[i]   = (rd_q[i] == fill_q[i]);
      more[i]    = (({1'b0, rd_q[i]} + 1'b1) < {1'b0, fill_q[i]});
      ld_hit[i]  = do_load && (32'(cmd_i.sel) == i) && (fill_q[i] != CW'(LIST_DEPTH));
      pop_hit[i] = do_pop && root.vld && (win == LW'(i));
    end
  end

  assign head_chg = do_clear || (|(ld_hit & empty)) || (do_pop && root.vld) || do_fill;
  assign wr_en    = |ld_hit;
  assign rd_en    = do_pop && root.vld && more[win];
  assign waddr    = AW'(AW'(sel_idx) * AW'(LIST_DEPTH)) + AW'(fill_q[sel_idx]);
  assign raddr    = AW'(AW'(win) * AW'(LIST_DEPTH)) + AW'(rd_q[win] + 1'b1);

  // min tree leaves
  for (genvar j = 0; j < P; j++) begin : g_leaf
    if (j < LISTS) begin : g_used
      assign leaf[j] = '{vld: head_vld_q[j], idx: LW'(j), val: head_val_q[j]};
    end else begin : g_pad
      assign leaf[j] = '{vld: 1'b0, idx: LW'(j), val: '0};
    end
  end

  always_comb begin
    for (int k = 1; k < P; k++) begin
      if (2 * k >= P) begin
        node_d[k] = pick(leaf[2 * k - P], leaf[2 * k + 1 - P]);
      end else begin
        node_d[k] = pick(node_q[2 * k], node_q[2 * k + 1]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 1; k < P; k++) begin
      node_q[k] <= node_d[k];
    end
  end

  // tree output is trusted only once the settle counter has run down with no head change
  always_comb begin
    if (head_chg) begin
      settle_d = SW'(LW);
    end else if (settle_q != '0) begin
      settle_d = settle_q - 1'b1;
    end else begin
      settle_d = settle_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q   <= SW'(LW);
      ovf_q      <= 1'b0;
      head_vld_q <= '0;
      for (int i = 0; i < LISTS; i++) begin
        fill_q[i] <= '0;
        rd_q[i]   <= '0;
      end
    end else begin
      settle_q <= settle_d;
      if (do_clear) begin
        ovf_q      <= 1'b0;
        head_vld_q <= '0;
        for (int i = 0; i < LISTS; i++) begin
          fill_q[i] <= '0;
          rd_q[i]   <= '0;
        end
      end else begin
        if (do_load && !wr_en) begin
          ovf_q <= 1'b1;
        end
        for (int i = 0; i < LISTS; i++) begin
          if (ld_hit[i]) begin
            fill_q[i] <= fill_q[i] + 1'b1;
            if (empty[i]) begin
              head_vld_q[i] <= 1'b1;
            end
          end
          if (pop_hit[i]) begin
            rd_q[i]       <= rd_q[i] + 1'b1;
            head_vld_q[i] <= more[i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < LISTS; i++) begin
      if (ld_hit[i] && empty[i]) begin
        head_val_q[i] <= cmd_i.value;
      end else if (do_fill && (fill_list_q == LW'(i))) begin
        head_val_q[i] <= rdata_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[waddr] <= cmd_i.value;
    end
    if (rd_en) begin
      rdata_q <= store_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      fill_list_q <= '0;
    end else begin
      if (out_valid_q && out_ready_i && !do_pop) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (take && (cmd_i.op == OP_POP)) begin
            state_q <= ST_POP;
          end
        end
        ST_POP: begin
          if (do_pop) begin
            out_valid_q         <= 1'b1;
            out_q.load_overflow <= ovf_q;
            fill_list_q         <= win;
            if (root.vld) begin
              out_q.merged_value    <= root.val;
              out_q.source_list     <= SEL_W'(win);
              out_q.lists_exhausted <= 1'b0;
              state_q               <= more[win] ? ST_FILL : ST_IDLE;
            end else begin
              out_q.merged_value    <= '0;
              out_q.source_list     <= '0;
              out_q.lists_exhausted <= 1'b1;
              state_q               <= ST_IDLE;
            end
          end
        end
        ST_FILL: state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ design/k_way_merge_engine_core.sv @@
// Path: an accepted item is registered in the front end, then queued in the command
//   FIFO; the back end registers a pop result once the head min tree is settled, and
//   loads and clears take effect in its list registers. Throughput: loads and clears
//   1 per cycle while no pop is in progress; a pop holds off further commands until
//   its result is out and any head refill done; pops wait for the min tree to settle.
// Reset: lists empty, overflow flag clear, no result pending; the store is not cleared.
module k_way_merge_engine_core #(
  parameter int unsigned LISTS      = kwm_pkg::LISTS_DEF,
  parameter int unsigned LIST_DEPTH = kwm_pkg::LIST_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  kwm_pkg::kwm_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output kwm_pkg::kwm_out_t out_o
);
  import kwm_pkg::*;

  logic     fe_valid, fe_ready;
  kwm_cmd_t fe_cmd;
  logic     q_valid, q_ready;
  kwm_cmd_t q_cmd;

  kwm_front #(.LISTS(LISTS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .cmd_valid_o (fe_valid),
    .cmd_ready_i (fe_ready),
    .cmd_o       (fe_cmd)
  );

  kwm_cmd_fifo u_cmd_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fe_valid),
    .push_ready_o (fe_ready),
    .push_i       (fe_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_o        (q_cmd)
  );

  kwm_back #(.LISTS(LISTS), .LIST_DEPTH(LIST_DEPTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

@@ design/kwm_checker.sv @@
// Port-level assertions for the merge engine and their binding to the top level.
module kwm_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input kwm_pkg::kwm_in_t  in_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input kwm_pkg::kwm_out_t out_o
);
  import kwm_pkg::*;

  logic seen_load_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_load_q <= 1'b0;
    end else if (in_valid_i && in_ready_o && (in_i.action == ACT_LOAD)) begin
      seen_load_q <= 1'b1;
    end
  end

  a_exhausted_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.lists_exhausted |-> (out_o.merged_value == '0) &&
                                             (out_o.source_list == '0))
    else $error("exhausted item carries nonzero value or list");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result item changed");

  a_ovf_needs_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.load_overflow |-> seen_load_q)
    else $error("overflow reported with no load since reset");

  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result item pending right after reset");

endmodule

bind k_way_merge_engine_core kwm_checker u_kwm_checker (.*);
